### design/i8btp_pkg.sv
`default_nettype none

package i8btp_pkg;

    localparam int BLOCK_ELEMS = 32;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_ELEMS);

    localparam logic [5:0]  HEADER_BYTES  = 6'd40;
    localparam logic [5:0]  SCALE_BYTES   = 6'd2;
    localparam logic [5:0]  BLOCK_BYTES   = 6'd34;
    localparam logic [31:0] RANK_REQUIRED = 32'd2;
    localparam logic [31:0] MAGIC_WORD    = 32'h3038494E;

    // header byte offsets
    localparam int MAGIC_BASE  = 0;
    localparam int AXIS_BASE   = 4;
    localparam int NEURON_BASE = 8;
    localparam int DIMS_BASE   = 12;
    localparam int OSHAPE_BASE = 16;
    localparam int ISHAPE_BASE = 24;
    localparam int OSIZE_BASE  = 32;
    localparam int GROUPS_BASE = 36;

    localparam logic [5:0] POS_MAGIC_CHECK  = 6'd3;
    localparam logic [5:0] POS_LAYOUT_CHECK = 6'd15;
    localparam logic [5:0] POS_DIMS_CHECK   = 6'd39;

    localparam int DATA_W = 96;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_LAYOUT  = 3'd3,
        ST_BAD_DIMS    = 3'd4,
        ST_PAYLOAD_LEN = 3'd5,
        ST_TOO_LARGE   = 3'd6
    } status_t;

endpackage

`default_nettype wire

### design/int8_block_tensor_parser.sv
// latency: a result word is registered and appears on m_axis in the cycle after its byte is accepted
// throughput: one byte per cycle; the only stall is back-pressure on the output register
// a byte yields a result word when it is a payload value or carries tlast
// reset: aresetn synchronous active low, clears byte/block counters, error and output valid
// after each tlast byte all parse state returns to reset for the next blob
`default_nettype none

module int8_block_tensor_parser #(
    parameter int ROW_LIMIT = 65536,
    parameter int COL_LIMIT = 16384
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // data_byte[7:0]
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // row_index[15:0], col_index[29:16], quant_value[37:30], block_scale[53:38],
    // status[56:54], row_count[73:57], col_count[88:74], zero[95:89]
    output logic [i8btp_pkg::DATA_W-1:0]        m_axis_tdata,
    output logic                                m_axis_tuser,   // elem_valid[0]
    output logic                                m_axis_tlast
);

    localparam int ROW_W = $clog2(64'(ROW_LIMIT) + 64'd1);
    localparam int GRP_W = $clog2(64'(COL_LIMIT / i8btp_pkg::BLOCK_ELEMS) + 64'd1);

    // control state
    logic [5:0]          pos_reg, pos_next;
    i8btp_pkg::status_t  err_reg, err_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [GRP_W-1:0]    grp_reg, grp_next;
    logic [5:0]          off_reg, off_next;
    logic                m_valid_reg;

    // header fields and block scale
    logic [23:0]         magic_reg;
    logic [31:0]         axis_reg;
    logic [31:0]         neuron_reg;
    logic [23:0]         dims_reg;
    logic [63:0]         oshape_reg;
    logic [63:0]         ishape_reg;
    logic [31:0]         osize_reg;
    logic [31:0]         groups_reg;
    logic [15:0]         scale_reg;

    logic [i8btp_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg;
    logic                m_last_reg;

    logic                in_accept;
    logic                hdr_phase;
    logic                hdr_take;
    logic                pay_take;
    logic                row_open;
    logic                elem;
    logic                produce;
    logic [31:0]         magic_full;
    logic [31:0]         dims_full;
    logic [31:0]         groups_full;
    logic [GRP_W:0]      grp_inc;
    logic [4:0]          lane;
    logic [GRP_W+4:0]    col_full;
    i8btp_pkg::status_t  st;
    logic                counts_ok;
    logic [15:0]         row_index;
    logic [13:0]         col_index;
    logic [7:0]          quant_value;
    logic [15:0]         block_scale;
    logic [2:0]          status_out;
    logic [16:0]         row_count;
    logic [14:0]         col_count;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign hdr_phase   = pos_reg < i8btp_pkg::HEADER_BYTES;
    assign row_open    = 32'(row_reg) < osize_reg;
    assign hdr_take    = in_accept && (err_reg == i8btp_pkg::ST_OK) && hdr_phase;
    assign pay_take    = in_accept && (err_reg == i8btp_pkg::ST_OK) && !hdr_phase && row_open;

    // the field's top byte is the one arriving at its check position
    assign magic_full  = {s_axis_tdata, magic_reg};
    assign dims_full   = {s_axis_tdata, dims_reg};
    assign groups_full = {s_axis_tdata, groups_reg[23:0]};

    assign grp_inc  = {1'b0, grp_reg} + {{GRP_W{1'b0}}, 1'b1};
    assign lane     = 5'(off_reg - i8btp_pkg::SCALE_BYTES);
    assign col_full = {grp_reg, lane};

    always_comb begin
        pos_next = pos_reg;
        err_next = err_reg;
        row_next = row_reg;
        grp_next = grp_reg;
        off_next = off_reg;
        elem     = 1'b0;
        if (err_reg == i8btp_pkg::ST_OK) begin
            if (hdr_phase) begin
                pos_next = pos_reg + 6'd1;
                priority if (pos_reg == i8btp_pkg::POS_MAGIC_CHECK) begin
                    if (magic_full != i8btp_pkg::MAGIC_WORD) begin
                        err_next = i8btp_pkg::ST_BAD_MAGIC;
                    end
                end else if (pos_reg == i8btp_pkg::POS_LAYOUT_CHECK) begin
                    if (dims_full != i8btp_pkg::RANK_REQUIRED || axis_reg != 32'd0 ||
                        neuron_reg == 32'd0 || neuron_reg[31] ||
                        neuron_reg[i8btp_pkg::BLOCK_SHIFT-1:0] != '0) begin
                        err_next = i8btp_pkg::ST_BAD_LAYOUT;
                    end
                end else if (pos_reg == i8btp_pkg::POS_DIMS_CHECK) begin
                    priority if (oshape_reg != 64'(osize_reg) ||
                                 ishape_reg != 64'(neuron_reg) ||
                                 osize_reg == 32'd0 ||
                                 groups_full != (neuron_reg >> i8btp_pkg::BLOCK_SHIFT)) begin
                        err_next = i8btp_pkg::ST_BAD_DIMS;
                    end else if (osize_reg > 32'(ROW_LIMIT) ||
                                 neuron_reg > 32'(COL_LIMIT)) begin
                        err_next = i8btp_pkg::ST_TOO_LARGE;
                    end else begin
                        err_next = err_reg;
                    end
                end else begin
                    err_next = err_reg;
                end
            end else if (!row_open) begin
                // byte beyond the complete payload
                err_next = i8btp_pkg::ST_PAYLOAD_LEN;
            end else begin
                elem = off_reg >= i8btp_pkg::SCALE_BYTES;
                if (off_reg == i8btp_pkg::BLOCK_BYTES - 6'd1) begin
                    off_next = 6'd0;
                    if (32'(grp_inc) >= groups_reg) begin
                        grp_next = '0;
                        row_next = row_reg + {{(ROW_W-1){1'b0}}, 1'b1};
                    end else begin
                        grp_next = grp_inc[GRP_W-1:0];
                    end
                end else begin
                    off_next = off_reg + 6'd1;
                end
            end
        end
    end

    // status and shape reflect the state after this byte
    always_comb begin
        priority if (err_next != i8btp_pkg::ST_OK) begin
            st = err_next;
        end else if (pos_next < i8btp_pkg::HEADER_BYTES) begin
            st = i8btp_pkg::ST_TRUNCATED;
        end else if (32'(row_next) < osize_reg) begin
            st = i8btp_pkg::ST_PAYLOAD_LEN;
        end else begin
            st = i8btp_pkg::ST_OK;
        end
    end

    assign counts_ok = (pos_next >= i8btp_pkg::HEADER_BYTES) &&
                       (st == i8btp_pkg::ST_OK || st == i8btp_pkg::ST_PAYLOAD_LEN);

    assign produce     = elem || s_axis_tlast;
    assign row_index   = elem ? 16'(row_reg) : 16'd0;
    assign col_index   = elem ? 14'(col_full) : 14'd0;
    assign quant_value = elem ? s_axis_tdata : 8'd0;
    assign block_scale = elem ? scale_reg : 16'd0;
    assign status_out  = s_axis_tlast ? st : i8btp_pkg::ST_OK;
    assign row_count   = (s_axis_tlast && counts_ok) ? osize_reg[16:0] : 17'd0;
    assign col_count   = (s_axis_tlast && counts_ok) ? neuron_reg[14:0] : 15'd0;
    assign m_data_next = {7'd0, col_count, row_count, status_out, block_scale,
                          quant_value, col_index, row_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 6'd0;
            err_reg     <= i8btp_pkg::ST_OK;
            row_reg     <= '0;
            grp_reg     <= '0;
            off_reg     <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                if (s_axis_tlast) begin
                    pos_reg <= 6'd0;
                    err_reg <= i8btp_pkg::ST_OK;
                    row_reg <= '0;
                    grp_reg <= '0;
                    off_reg <= 6'd0;
                end else begin
                    pos_reg <= pos_next;
                    err_reg <= err_next;
                    row_reg <= row_next;
                    grp_reg <= grp_next;
                    off_reg <= off_next;
                end
            end
            if (in_accept && produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hdr_take) begin
            for (int k = 0; k < 3; k++) begin
                if (pos_reg == 6'(i8btp_pkg::MAGIC_BASE + k)) magic_reg[8*k +: 8] <= s_axis_tdata;
                if (pos_reg == 6'(i8btp_pkg::DIMS_BASE + k))  dims_reg[8*k +: 8]  <= s_axis_tdata;
            end
            for (int k = 0; k < 4; k++) begin
                if (pos_reg == 6'(i8btp_pkg::AXIS_BASE + k))   axis_reg[8*k +: 8]   <= s_axis_tdata;
                if (pos_reg == 6'(i8btp_pkg::NEURON_BASE + k)) neuron_reg[8*k +: 8] <= s_axis_tdata;
                if (pos_reg == 6'(i8btp_pkg::OSIZE_BASE + k))  osize_reg[8*k +: 8]  <= s_axis_tdata;
                if (pos_reg == 6'(i8btp_pkg::GROUPS_BASE + k)) groups_reg[8*k +: 8] <= s_axis_tdata;
            end
            for (int k = 0; k < 8; k++) begin
                if (pos_reg == 6'(i8btp_pkg::OSHAPE_BASE + k)) oshape_reg[8*k +: 8] <= s_axis_tdata;
                if (pos_reg == 6'(i8btp_pkg::ISHAPE_BASE + k)) ishape_reg[8*k +: 8] <= s_axis_tdata;
            end
        end
        if (pay_take) begin
            if (off_reg == 6'd0) scale_reg[7:0]  <= s_axis_tdata;
            if (off_reg == 6'd1) scale_reg[15:8] <= s_axis_tdata;
        end
        if (in_accept && produce) begin
            m_data_reg <= m_data_next;
            m_user_reg <= elem;
            m_last_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

### design/i8btp_checker.sv
`default_nettype none

module i8btp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [7:0]                     s_axis_tdata,
    input wire logic                           s_axis_tlast,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [i8btp_pkg::DATA_W-1:0]   m_axis_tdata,
    input wire logic                           m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    logic [2:0] status_f;
    logic       in_word;

    assign status_f = m_axis_tdata[56:54];
    assign in_word  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata) &&
                      (s_axis_tlast == s_axis_tlast);

    // an empty output register always takes a byte
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // every word carries an element or the end report
    a_word_has_purpose: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("result word with neither element nor end flag");

    a_elem_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[53:0] == '0)
        else $error("element fields set on a non-element word");

    // shape only reported when the header was accepted
    a_shape_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (!m_axis_tlast ||
            (status_f != i8btp_pkg::ST_OK && status_f != i8btp_pkg::ST_PAYLOAD_LEN))
        |-> m_axis_tdata[95:57] == '0)
        else $error("shape reported without an accepted header");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready && !in_word |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

endmodule

bind int8_block_tensor_parser i8btp_checker u_i8btp_checker (.*);

`default_nettype wire
